// ===== rtl/imhq_pkg.sv =====
// Package: shared types and constants of the indexed min-heap queue.
`timescale 1ns / 1ps
package imhq_pkg;
    typedef enum logic [1:0] {
        K_ADD     = 2'd0,
        K_EXTRACT = 2'd1,
        K_REDUCE  = 2'd2,
        K_MEMBER  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_OVERFLOW  = 3'd1,
        ST_UNDERFLOW = 3'd2,
        ST_ABSENT    = 3'd3,
        ST_DUPLICATE = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_DISPATCH,
        S_UP_RD,
        S_UP_CMP,
        S_EX_RD,
        S_EX_WR,
        S_DN_RD,
        S_DN_RD2,
        S_DN_CMP,
        S_DN_SW,
        S_DONE
    } t_state;

    localparam int unsigned VALUE_BITS = 64;
    localparam int unsigned TDATA_IN_BITS = 80;
    localparam int unsigned TDATA_OUT_BITS = 80;
endpackage

// ===== rtl/imhq_mem.sv =====
// Module: heap entry memory, one write port and one registered read port.
`timescale 1ns / 1ps
module imhq_mem #(
    parameter int AW = 8,
    parameter int DW = 80
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/indexed_min_heap_queue_top.sv =====
// Top level: indexed min-heap queue with add, extract, reduce key and membership.
`timescale 1ns / 1ps
// One operation is in flight at a time; the heap sits in one single-port-read
// memory of CAPACITY entries (key and value side by side). The value lookup scans
// the occupied entries, reading then comparing each, for add, reduce key and
// membership before the sift; sift up reads and compares the parent per level,
// sift down reads both children, compares and swaps, over log2(CAPACITY) levels. A
// result waits in the output register and is handed out on the master side; the
// next input is taken once that result is accepted. No clearing pass follows reset.
module indexed_min_heap_queue_top #(
    parameter int CAPACITY = 256,
    parameter int KEY_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [15:0] priority_key, [79:16] item_value
    input  logic [imhq_pkg::TDATA_IN_BITS-1:0] s_axis_tdata,
    // [1:0] kind
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [63:0] min_value, [64] is_present, [67:65] status, [76:68] occupancy,
    // [77] is_empty, [79:78] zero
    output logic [imhq_pkg::TDATA_OUT_BITS-1:0] m_axis_tdata
);
    import imhq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = AW + 2;
    localparam int DW = KEY_BITS + VALUE_BITS;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    t_state r_state, n_state;
    t_kind r_kind, n_kind;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [VALUE_BITS-1:0] r_val, n_val;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_pos, n_pos;
    logic r_found, n_found;
    logic [DW-1:0] r_cur, n_cur;
    logic [DW-1:0] r_lft, n_lft;
    logic [VALUE_BITS-1:0] r_minv, n_minv;
    logic r_ovalid, n_ovalid;
    logic [TDATA_OUT_BITS-1:0] r_odata, n_odata;

    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [DW-1:0] wdata, rdata;

    imhq_mem #(.AW(AW), .DW(DW)) u_mem (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    logic [XW-1:0] lchild, rchild, cnt_x;
    logic [AW-1:0] parent;
    logic [KEY_BITS-1:0] rkey, ckey, lkey;
    assign lchild = {1'b0, r_pos, 1'b1};
    assign rchild = lchild + XW'(1);
    assign cnt_x  = XW'(r_cnt);
    assign parent = AW'((r_pos - 1'b1) >> 1);
    assign rkey = rdata[DW-1 -: KEY_BITS];
    assign ckey = r_cur[DW-1 -: KEY_BITS];
    assign lkey = r_lft[DW-1 -: KEY_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
        r_kind <= n_kind; r_key <= n_key; r_val <= n_val; r_idx <= n_idx;
        r_pos <= n_pos; r_found <= n_found; r_cur <= n_cur; r_lft <= n_lft;
        r_minv <= n_minv; r_odata <= n_odata;
    end

    task automatic finish(input t_status st, input logic pres,
                          input logic [CW-1:0] cnt);
        n_odata  = '0;
        n_odata[63:0]  = (st == ST_OK && r_kind == K_EXTRACT) ? r_minv : '0;
        n_odata[64]    = pres;
        n_odata[67:65] = st;
        n_odata[76:68] = 9'(cnt);
        n_odata[77]    = (cnt == '0);
        n_ovalid = 1'b1;
        n_state  = S_IDLE;
    endtask

    always_comb begin
        n_state = r_state; n_kind = r_kind; n_key = r_key; n_val = r_val;
        n_cnt = r_cnt; n_idx = r_idx; n_pos = r_pos; n_found = r_found;
        n_cur = r_cur; n_lft = r_lft; n_minv = r_minv;
        n_ovalid = r_ovalid; n_odata = r_odata;
        we = 1'b0; waddr = r_pos; wdata = r_cur; raddr = r_pos;
        if (m_axis_tvalid && m_axis_tready) n_ovalid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    n_kind  = t_kind'(s_axis_tuser);
                    n_key   = KEY_BITS'(s_axis_tdata[15:0]);
                    n_val   = s_axis_tdata[79:16];
                    n_idx   = '0;
                    n_found = 1'b0;
                    if (t_kind'(s_axis_tuser) == K_EXTRACT) n_state = S_EX_RD;
                    else if (t_kind'(s_axis_tuser) == K_ADD && r_cnt >= CAP_C)
                        n_state = S_DISPATCH;
                    else n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                if (r_idx >= r_cnt) n_state = S_DISPATCH;
                else begin
                    raddr = AW'(r_idx);
                    n_state = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if (rdata[VALUE_BITS-1:0] == r_val) begin
                    n_found = 1'b1;
                    n_pos = AW'(r_idx);
                    n_cur = rdata;
                    n_state = S_DISPATCH;
                end else begin
                    n_idx = r_idx + 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_DISPATCH: begin
                case (r_kind)
                    K_ADD: begin
                        if (r_cnt >= CAP_C) finish(ST_OVERFLOW, 1'b0, r_cnt);
                        else if (r_found) finish(ST_DUPLICATE, 1'b0, r_cnt);
                        else begin
                            n_cnt = r_cnt + 1'b1;
                            n_pos = AW'(r_cnt);
                            n_cur = {r_key, r_val};
                            we = 1'b1; waddr = AW'(r_cnt); wdata = {r_key, r_val};
                            n_state = S_UP_RD;
                        end
                    end
                    K_REDUCE: begin
                        if (!r_found) finish(ST_ABSENT, 1'b0, r_cnt);
                        else if (ckey < r_key) finish(ST_OK, 1'b0, r_cnt);
                        else begin
                            n_cur = {r_key, r_cur[VALUE_BITS-1:0]};
                            we = 1'b1; wdata = {r_key, r_cur[VALUE_BITS-1:0]};
                            n_state = S_UP_RD;
                        end
                    end
                    default: finish(ST_OK, r_found, r_cnt);
                endcase
            end
            S_UP_RD: begin
                if (r_pos == '0) begin
                    we = 1'b1; waddr = r_pos; wdata = r_cur;
                    finish(ST_OK, 1'b0, r_cnt);
                end else begin
                    raddr = parent;
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (rkey > ckey) begin
                    we = 1'b1; waddr = r_pos; wdata = rdata;
                    n_pos = parent;
                    n_state = S_UP_RD;
                end else begin
                    we = 1'b1; waddr = r_pos; wdata = r_cur;
                    finish(ST_OK, 1'b0, r_cnt);
                end
            end
            S_EX_RD: begin
                if (r_cnt == '0) finish(ST_UNDERFLOW, 1'b0, r_cnt);
                else begin
                    raddr = '0;
                    n_state = S_EX_WR;
                end
            end
            S_EX_WR: begin
                n_minv = rdata[VALUE_BITS-1:0];
                raddr = AW'(r_cnt - 1'b1);
                n_cnt = r_cnt - 1'b1;
                n_pos = '0;
                n_state = S_DN_RD;
            end
            S_DN_RD: begin
                // first visit: rdata holds the last entry
                n_cur = rdata;
                n_state = S_DN_RD2;
                if (lchild < cnt_x) raddr = AW'(lchild);
                else begin
                    we = 1'b1; waddr = r_pos; wdata = rdata;
                    finish(ST_OK, 1'b0, r_cnt);
                end
            end
            S_DN_RD2: begin
                n_lft = rdata;
                raddr = AW'(rchild);
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (rchild < cnt_x && rkey < ckey && rkey < lkey) begin
                    we = 1'b1; waddr = r_pos; wdata = rdata;
                    n_pos = AW'(rchild);
                    n_state = S_DN_SW;
                end else if (lkey < ckey) begin
                    we = 1'b1; waddr = r_pos; wdata = r_lft;
                    n_pos = AW'(lchild);
                    n_state = S_DN_SW;
                end else begin
                    we = 1'b1; waddr = r_pos; wdata = r_cur;
                    finish(ST_OK, 1'b0, r_cnt);
                end
            end
            S_DN_SW: begin
                if (lchild < cnt_x) begin
                    raddr = AW'(lchild);
                    n_state = S_DN_RD2;
                end else begin
                    we = 1'b1; waddr = r_pos; wdata = r_cur;
                    finish(ST_OK, 1'b0, r_cnt);
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    property p_out_hold;
        @(posedge i_clk) disable iff (!i_rst_n)
            m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata);
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("result dropped");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CAP_C) else $error("occupancy above capacity");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> !s_axis_tready) else $error("input taken with result pending");
endmodule

// ===== bench/tb_top.sv =====
// Testbench: self-checking stream bench for the indexed min-heap queue.
`timescale 1ns / 1ps
module tb_top;
    import imhq_pkg::*;

    localparam int CAP = 256;
    localparam int KEY_BITS = 16;
    localparam logic [15:0] KEY_MAX = 16'hFFFF;
    localparam int CYCLE_LIMIT = 10000000;
    localparam int TARGET_ITEMS = 1950;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] key;
        logic [63:0] val;
    } t_op;

    typedef struct packed {
        logic [63:0] min_value;
        logic        is_present;
        logic [2:0]  status;
        logic [8:0]  occupancy;
        logic        is_empty;
    } t_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [15:0] priority_key, [79:16] item_value
    logic [TDATA_IN_BITS-1:0] s_axis_tdata = '0;
    // [1:0] kind
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [63:0] min_value, [64] is_present, [67:65] status, [76:68] occupancy,
    // [77] is_empty, [79:78] zero
    logic [TDATA_OUT_BITS-1:0] m_axis_tdata;

    indexed_min_heap_queue_top #(.CAPACITY(CAP), .KEY_BITS(KEY_BITS)) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    logic [15:0] heap_key [CAP];
    logic [63:0] heap_val [CAP];
    int          heap_count = 0;

    t_op    pending_ops [$];
    t_reply planned_replies [$];
    t_reply awaited_replies [$];

    int error_count = 0;
    int reply_count = 0;
    int accepted_count = 0;
    int cycle_count = 0;
    int peak_count = 0;
    int status_seen [5];
    bit stimulus_done = 1'b0;

    function automatic int find_slot(logic [63:0] v);
        for (int i = 0; i < heap_count; i++) begin
            if (heap_val[i] == v) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic void swap_slots(int a, int b);
        logic [15:0] tk;
        logic [63:0] tv;
        tk = heap_key[a];
        tv = heap_val[a];
        heap_key[a] = heap_key[b];
        heap_val[a] = heap_val[b];
        heap_key[b] = tk;
        heap_val[b] = tv;
    endfunction

    function automatic void lower_and_rise(int pos, logic [15:0] k);
        int up;
        if (heap_key[pos] < k) begin
            return;
        end
        heap_key[pos] = k;
        while (pos > 0) begin
            up = (pos - 1) / 2;
            if (heap_key[up] > heap_key[pos]) begin
                swap_slots(pos, up);
                pos = up;
            end else begin
                break;
            end
        end
    endfunction

    function automatic void sink_root();
        int pos;
        int l;
        int r;
        int best;
        pos = 0;
        forever begin
            l = 2 * pos + 1;
            r = 2 * pos + 2;
            best = pos;
            if (l < heap_count && heap_key[l] < heap_key[best]) begin
                best = l;
            end
            if (r < heap_count && heap_key[r] < heap_key[best]) begin
                best = r;
            end
            if (best == pos) begin
                return;
            end
            swap_slots(pos, best);
            pos = best;
        end
    endfunction

    function automatic t_reply heap_apply(t_op op);
        t_reply rep;
        int slot;
        rep = '0;
        rep.status = ST_OK;
        case (op.kind)
            K_ADD: begin
                if (heap_count >= CAP) begin
                    rep.status = ST_OVERFLOW;
                end else if (find_slot(op.val) >= 0) begin
                    rep.status = ST_DUPLICATE;
                end else begin
                    slot = heap_count;
                    heap_key[slot] = KEY_MAX;
                    heap_val[slot] = op.val;
                    heap_count++;
                    lower_and_rise(slot, op.key);
                end
            end
            K_EXTRACT: begin
                if (heap_count == 0) begin
                    rep.status = ST_UNDERFLOW;
                end else begin
                    rep.min_value = heap_val[0];
                    heap_count--;
                    heap_key[0] = heap_key[heap_count];
                    heap_val[0] = heap_val[heap_count];
                    sink_root();
                end
            end
            K_REDUCE: begin
                slot = find_slot(op.val);
                if (slot >= 0) begin
                    lower_and_rise(slot, op.key);
                end else begin
                    rep.status = ST_ABSENT;
                end
            end
            default: begin
                rep.is_present = (find_slot(op.val) >= 0);
            end
        endcase
        rep.occupancy = heap_count[8:0];
        rep.is_empty = (heap_count == 0);
        if (heap_count > peak_count) begin
            peak_count = heap_count;
        end
        status_seen[rep.status]++;
        return rep;
    endfunction

    task automatic plan_op(t_kind k, logic [15:0] key, logic [63:0] v);
        t_op op;
        op.kind = k;
        op.key = key;
        op.val = v;
        pending_ops.push_back(op);
        planned_replies.push_back(heap_apply(op));
    endtask

    function automatic logic [63:0] rand_value();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [15:0] rand_key();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            return 16'h0000;
        end else if (sel == 1) begin
            return KEY_MAX;
        end else if (sel == 2) begin
            return 16'($urandom_range(0, 15));
        end
        return 16'($urandom());
    endfunction

    function automatic logic [63:0] pick_value();
        if (heap_count > 0 && $urandom_range(0, 9) < 5) begin
            return heap_val[$urandom_range(0, heap_count - 1)];
        end
        return rand_value();
    endfunction

    task automatic plan_random(int low_mark, int high_mark);
        int sel;
        t_kind k;
        sel = $urandom_range(0, 99);
        if (heap_count < low_mark) begin
            k = (sel < 60) ? K_ADD : (sel < 75) ? K_REDUCE : (sel < 90) ? K_MEMBER : K_EXTRACT;
        end else if (heap_count > high_mark) begin
            k = (sel < 50) ? K_EXTRACT : (sel < 65) ? K_ADD : (sel < 85) ? K_REDUCE : K_MEMBER;
        end else begin
            k = t_kind'(sel % 4);
        end
        plan_op(k, rand_key(), pick_value());
    endtask

    initial begin
        for (int i = 0; i < 5; i++) begin
            status_seen[i] = 0;
        end
        plan_op(K_EXTRACT, 16'h0000, 64'h0);
        plan_op(K_MEMBER, 16'h0000, 64'h0);
        plan_op(K_REDUCE, 16'h1234, 64'h0);
        plan_op(K_ADD, KEY_MAX, 64'hFFFF_FFFF_FFFF_FFFF);
        plan_op(K_ADD, 16'h0000, 64'h0);
        plan_op(K_ADD, 16'h8000, 64'h5555_AAAA_5555_AAAA);
        plan_op(K_ADD, 16'h8000, 64'hAAAA_5555_AAAA_5555);
        plan_op(K_ADD, 16'h7FFF, 64'h0);
        plan_op(K_MEMBER, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        plan_op(K_MEMBER, 16'h0000, 64'h1);
        plan_op(K_REDUCE, KEY_MAX, 64'h5555_AAAA_5555_AAAA);
        plan_op(K_REDUCE, 16'h8000, 64'hAAAA_5555_AAAA_5555);
        plan_op(K_REDUCE, 16'h0000, 64'hFFFF_FFFF_FFFF_FFFF);
        plan_op(K_REDUCE, 16'h0000, 64'h8000_0000_0000_0000);
        plan_op(K_ADD, 16'h0000, 64'h8000_0000_0000_0000);
        for (int i = 0; i < 6; i++) begin
            plan_op(K_EXTRACT, 16'($urandom()), rand_value());
        end
        plan_op(K_EXTRACT, 16'h0000, 64'h0);
        plan_op(K_MEMBER, 16'h0000, 64'h0);

        for (int i = 0; i < 750; i++) begin
            plan_random(4, 40);
        end
        while (heap_count < CAP) begin
            if ($urandom_range(0, 9) == 0) begin
                plan_random(CAP, CAP);
            end else begin
                plan_op(K_ADD, rand_key(), pick_value());
            end
        end
        for (int i = 0; i < 8; i++) begin
            plan_op($urandom_range(0, 1) ? K_ADD : t_kind'($urandom_range(2, 3)),
                    rand_key(), pick_value());
        end
        while (heap_count > 0) begin
            if ($urandom_range(0, 7) == 0) begin
                plan_op(t_kind'($urandom_range(2, 3)), rand_key(), pick_value());
            end else begin
                plan_op(K_EXTRACT, rand_key(), rand_value());
            end
        end
        plan_op(K_EXTRACT, rand_key(), rand_value());
        plan_op(K_REDUCE, rand_key(), rand_value());
        while (pending_ops.size() < TARGET_ITEMS) begin
            plan_random(2, 24);
        end
        stimulus_done = 1'b1;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_ops.size() == 0 && !s_axis_tvalid);
        wait (awaited_replies.size() == 0 && planned_replies.size() == 0);
        repeat (800) @(posedge i_clk);
        $display("tb_top: %0d operations driven, %0d replies checked, peak occupancy %0d",
                 accepted_count, reply_count, peak_count);
        $display("tb_top: replies by status ok/ovf/udf/absent/dup = %0d/%0d/%0d/%0d/%0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (error_count == 0 && awaited_replies.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    int send_gap = 0;

    always @(posedge i_clk) begin
        logic next_valid;
        t_op  op;
        next_valid = s_axis_tvalid;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                awaited_replies.push_back(planned_replies.pop_front());
                accepted_count++;
                next_valid = 1'b0;
                if ($urandom_range(0, 3) == 0) begin
                    send_gap = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 120)
                                                              : $urandom_range(1, 3);
                end
            end
            if (!next_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_ops.size() > 0) begin
                    op = pending_ops.pop_front();
                    s_axis_tdata <= {op.val, op.key};
                    s_axis_tuser <= op.kind;
                    next_valid = 1'b1;
                end
            end
        end
        s_axis_tvalid <= next_valid;
    end

    int  hold_cycles = 0;
    bit  pressure_done = 1'b0;

    always @(posedge i_clk) begin
        t_reply got;
        t_reply want;
        logic   next_ready;
        if (m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[63:0], m_axis_tdata[64], m_axis_tdata[67:65],
                   m_axis_tdata[76:68], m_axis_tdata[77]};
            reply_count++;
            if (awaited_replies.size() == 0) begin
                $error("unexpected reply transaction %h", m_axis_tdata);
                error_count++;
            end else begin
                want = awaited_replies.pop_front();
                if (got.min_value !== want.min_value) begin
                    $error("min_value expected %h actual %h", want.min_value, got.min_value);
                    error_count++;
                end
                if (got.is_present !== want.is_present) begin
                    $error("is_present expected %0d actual %0d",
                           want.is_present, got.is_present);
                    error_count++;
                end
                if (got.status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, got.status);
                    error_count++;
                end
                if (got.occupancy !== want.occupancy) begin
                    $error("occupancy expected %0d actual %0d",
                           want.occupancy, got.occupancy);
                    error_count++;
                end
                if (got.is_empty !== want.is_empty) begin
                    $error("is_empty expected %0d actual %0d", want.is_empty, got.is_empty);
                    error_count++;
                end
                if (m_axis_tdata[79:78] !== 2'b00) begin
                    $error("pad bits expected 0 actual %b", m_axis_tdata[79:78]);
                    error_count++;
                end
            end
        end
        if (hold_cycles > 0) begin
            hold_cycles--;
            next_ready = 1'b0;
        end else if (!pressure_done && reply_count >= 400) begin
            pressure_done = 1'b1;
            hold_cycles = 3000;
            next_ready = 1'b0;
        end else if (reply_count > 1200 && reply_count < 1400) begin
            next_ready = 1'b1;
        end else if ($urandom_range(0, 4) == 0) begin
            hold_cycles = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 150)
                                                         : $urandom_range(0, 3);
            next_ready = 1'b0;
        end else begin
            next_ready = 1'b1;
        end
        m_axis_tready <= next_ready;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end
endmodule

// ===== filelist.f =====
rtl/imhq_pkg.sv
rtl/imhq_mem.sv
rtl/indexed_min_heap_queue_top.sv
bench/tb_top.sv
